>>> hw/rtl/rtmc_pkg.sv
// Shared constants, payload types and channel arithmetic for the tile mip chain builder.
package rtmc_pkg;

  // Tile geometry: a 64x64 tile gives levels 1 to 6.
  localparam int unsigned TileLog2   = 6;
  localparam int unsigned Channels   = 4;
  localparam int unsigned PosW       = 2 * TileLog2;
  localparam int unsigned LvlPosW    = 2 * (TileLog2 - 1);
  localparam int unsigned CoordW     = TileLog2 - 1;
  localparam int unsigned BackLevels = TileLog2 - 1;
  localparam int unsigned FrontPairs = 1 << (TileLog2 - 1);
  localparam int unsigned BackPairs  = FrontPairs - 1;
  localparam int unsigned BackPairAw = TileLog2 - 1;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = QueuePtrW + 1;
  localparam int unsigned LevelW     = 3;
  localparam logic [LevelW-1:0] TopLevel = LevelW'(TileLog2);

  typedef logic [Channels-1:0][7:0] pix_t;
  typedef logic [Channels-1:0][8:0] pair_t;

  typedef struct packed {
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [2:0] level;
    logic [4:0] col;
    logic [4:0] row;
    logic [7:0] out0;
    logic [7:0] out1;
    logic [7:0] out2;
    logic [7:0] out3;
    logic       last;
  } out_t;

  // One level-1 pixel handed from the front to the back.
  typedef struct packed {
    logic              restart;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    pix_t              px;
  } entry_t;

  // Per-channel sum of a horizontal pixel pair.
  function automatic pair_t pair_sum(input pix_t a, input pix_t b);
    pair_t s;
    for (int k = 0; k < Channels; k++) begin
      s[k] = {1'b0, a[k]} + {1'b0, b[k]};
    end
    return s;
  endfunction

  // Rounded 2x2 box average from the upper pair sum and the lower pair.
  function automatic pix_t box_avg(input pair_t p, input pix_t a, input pix_t b);
    logic [9:0] s;
    pix_t       r;
    for (int k = 0; k < Channels; k++) begin
      s    = {1'b0, p[k]} + {2'b00, a[k]} + {2'b00, b[k]} + 10'd2;
      r[k] = s[9:2];
    end
    return r;
  endfunction

  // First pair-store slot of a back level: levels are packed one after another.
  function automatic logic [BackPairAw-1:0] pair_base(input logic [LevelW-1:0] level);
    logic [BackPairAw:0] b;
    b = (BackPairAw + 1)'(FrontPairs) - ((BackPairAw + 1)'(FrontPairs) >> (level - 3'd1));
    return b[BackPairAw-1:0];
  endfunction

endpackage

>>> hw/rtl/rgba_tile_mip_chain.sv
// Top level of the streaming mip chain builder for one 64x64 RGBA tile.
//
// Pixels of a 64x64 four-channel tile enter in raster order, column fastest, and
// one is taken every cycle while the queue between the level-0 front and the
// level-1..6 back has room. The front forms each level-1 pixel (a rounded 2x2
// box average) in the cycle its pixel is taken; it passes through the queue and
// the back's current-pixel register into the output register. The back emits one
// result per cycle while the output is not stalled and builds each deeper level
// from the rounded level above, one level step per cycle, so an input that
// completes k levels yields k results, in ascending level order with last set on
// the final one. Inputs average about a third of a result each; the four-entry
// queue absorbs the bursts at the bottom rows of level blocks, so the input
// stalls only when the output side is held back. A pixel with restart set starts
// a new tile; a tile also wraps to a new one by itself after its last pixel.
module rgba_tile_mip_chain (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  rtmc_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output rtmc_pkg::out_t out_data_o,
  input  logic           out_stall_i
);

  logic             push, pop, full, empty;
  rtmc_pkg::entry_t push_data, head;

  // Level-0 front end.
  rtmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Level-1 pixel queue.
  rtmc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  // Level walk and result output.
  rtmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> hw/rtl/rtmc_front.sv
// Level-0 front end: tracks the tile position and forms level-1 pixels at full rate while the queue has room.
module rtmc_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  rtmc_pkg::in_t          in_data_i,
  output logic                   in_stall_o,
  input  logic                   full_i,
  output logic                   push_o,
  output rtmc_pkg::entry_t       push_data_o
);

  logic [rtmc_pkg::PosW-1:0]     pos_q, pos_d, p;
  logic [rtmc_pkg::TileLog2-1:0] c, r;
  logic [rtmc_pkg::CoordW-1:0]   hc;
  rtmc_pkg::pix_t                px, hold_q;
  rtmc_pkg::pair_t               pair_mem [rtmc_pkg::FrontPairs];
  logic                          pend_q;
  logic                          accept;

  // The input side stalls only while the queue to the back is full.
  assign in_stall_o = full_i;
  assign accept     = in_valid_i & ~full_i;

  // Position decode and level-1 pixel formation.
  always_comb begin
    px[0] = in_data_i.chan0;
    px[1] = in_data_i.chan1;
    px[2] = in_data_i.chan2;
    px[3] = in_data_i.chan3;
    p     = in_data_i.restart ? '0 : pos_q;
    c     = p[rtmc_pkg::TileLog2-1:0];
    r     = p[rtmc_pkg::PosW-1:rtmc_pkg::TileLog2];
    hc    = c[rtmc_pkg::TileLog2-1:1];
    pos_d = accept ? p + 1'b1 : pos_q;
    push_o              = accept & c[0] & r[0];
    push_data_o.restart = pend_q | in_data_i.restart;
    push_data_o.col     = hc;
    push_data_o.row     = r[rtmc_pkg::TileLog2-1:1];
    push_data_o.px      = rtmc_pkg::box_avg(pair_mem[hc], hold_q, px);
  end

  // Position, left pixel and the pending restart that travels to the back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hold_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (accept && !c[0]) begin
        hold_q <= px;
      end
      if (accept) begin
        pend_q <= push_o ? 1'b0 : (pend_q | in_data_i.restart);
      end
    end
  end

  // Upper pair sums of level 0, written on even rows and read on odd rows.
  always_ff @(posedge clk_i) begin
    if (accept && c[0] && !r[0]) begin
      pair_mem[hc] <= rtmc_pkg::pair_sum(hold_q, px);
    end
  end

endmodule

>>> hw/rtl/rtmc_queue.sv
// Short queue of level-1 pixels between the front and the back.
module rtmc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rtmc_pkg::entry_t push_data_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output rtmc_pkg::entry_t head_o
);

  rtmc_pkg::entry_t                mem [rtmc_pkg::QueueDepth];
  logic [rtmc_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [rtmc_pkg::QueueCntW-1:0]  cnt_q;

  assign full_o  = cnt_q == rtmc_pkg::QueueCntW'(rtmc_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/rtmc_back.sv
// Back end: emits level pixels and walks levels 1 to 5, one level step per cycle while the output is not stalled.
module rtmc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  rtmc_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output rtmc_pkg::out_t   out_data_o,
  input  logic             out_stall_i
);

  // Pixel being emitted and applied to its level.
  logic                          cur_valid_q;
  logic [rtmc_pkg::LevelW-1:0]   cur_level_q;
  logic [rtmc_pkg::CoordW-1:0]   cur_col_q, cur_row_q;
  rtmc_pkg::pix_t                cur_px_q;

  // Per-level state of levels 1 to 5.
  logic [rtmc_pkg::LvlPosW-1:0]  pos_q [rtmc_pkg::BackLevels];
  rtmc_pkg::pix_t                hold_q [rtmc_pkg::BackLevels];
  rtmc_pkg::pair_t               pair_mem [rtmc_pkg::BackPairs];

  logic                          out_valid_q;
  rtmc_pkg::out_t                out_q, emit;

  logic                          step, proc, cont, load;
  logic [rtmc_pkg::LevelW-1:0]   idx, lg;
  logic [rtmc_pkg::LvlPosW-1:0]  pos, smask, nxt;
  logic [rtmc_pkg::LvlPosW:0]    nxt_full;
  logic [rtmc_pkg::CoordW-1:0]   c5, r5;
  logic [rtmc_pkg::BackPairAw-1:0] addr;
  rtmc_pkg::pix_t                avg;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Level step: position decode, pair store address and the next-level average.
  always_comb begin
    step     = cur_valid_q & (~out_valid_q | ~out_stall_i);
    proc     = cur_level_q != rtmc_pkg::TopLevel;
    idx      = proc ? cur_level_q - 3'd1 : '0;
    lg       = rtmc_pkg::LevelW'(rtmc_pkg::TileLog2) - cur_level_q;
    pos      = pos_q[idx];
    smask    = (rtmc_pkg::LvlPosW'(1) << lg) - 1'b1;
    c5       = rtmc_pkg::CoordW'(pos & smask);
    r5       = rtmc_pkg::CoordW'((pos >> lg) & smask);
    nxt_full = ({1'b0, pos} + 1'b1) &
               (((rtmc_pkg::LvlPosW + 1)'(1) << {lg, 1'b0}) - 1'b1);
    nxt      = nxt_full[rtmc_pkg::LvlPosW-1:0];
    addr     = proc ? rtmc_pkg::pair_base(cur_level_q) + {1'b0, c5[rtmc_pkg::CoordW-1:1]}
                    : '0;
    avg      = rtmc_pkg::box_avg(pair_mem[addr], hold_q[idx], cur_px_q);
    cont     = proc & c5[0] & r5[0];
    load     = (~cur_valid_q | (step & ~cont)) & ~empty_i;
    pop_o    = load;

    emit.level = cur_level_q;
    emit.col   = cur_col_q;
    emit.row   = cur_row_q;
    emit.out0  = cur_px_q[0];
    emit.out1  = cur_px_q[1];
    emit.out2  = cur_px_q[2];
    emit.out3  = cur_px_q[3];
    emit.last  = ~cont;
  end

  // Control state, level positions and left pixels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < rtmc_pkg::BackLevels; i++) begin
        pos_q[i]  <= '0;
        hold_q[i] <= '0;
      end
    end else begin
      if (step && cont) begin
        cur_valid_q <= 1'b1;
      end else if (!cur_valid_q || step) begin
        cur_valid_q <= ~empty_i;
      end

      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // A restart carried by the next level-1 pixel clears all level positions.
      if (load && head_i.restart) begin
        for (int i = 0; i < rtmc_pkg::BackLevels; i++) begin
          pos_q[i] <= '0;
        end
      end else if (step && proc) begin
        pos_q[idx] <= nxt;
      end

      if (step && proc && !c5[0]) begin
        hold_q[idx] <= cur_px_q;
      end
    end
  end

  // Payload registers and the pair store of levels 1 to 5.
  always_ff @(posedge clk_i) begin
    if (step && cont) begin
      cur_level_q <= cur_level_q + 3'd1;
      cur_col_q   <= {1'b0, c5[rtmc_pkg::CoordW-1:1]};
      cur_row_q   <= {1'b0, r5[rtmc_pkg::CoordW-1:1]};
      cur_px_q    <= avg;
    end else if (load) begin
      cur_level_q <= 3'd1;
      cur_col_q   <= head_i.col;
      cur_row_q   <= head_i.row;
      cur_px_q    <= head_i.px;
    end

    if (step) begin
      out_q <= emit;
    end

    if (step && proc && c5[0] && !r5[0]) begin
      pair_mem[addr] <= rtmc_pkg::pair_sum(hold_q[idx], cur_px_q);
    end
  end

endmodule
